// File: rtl/core/ocp_pkg.sv
package ocp_pkg;

  // Result-bit stages of the iterative units.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 22;

  typedef logic signed [31:0] coord_t;
  typedef logic [63:0]        sumsq_t;
  typedef logic [31:0]        root_t;
  typedef logic [56:0]        denom_t;
  typedef logic [21:0]        quot_t;
  typedef logic signed [19:0] pixel_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MIRROR_XI  = 3'd0,
    REG_FOCAL_X    = 3'd1,
    REG_FOCAL_Y    = 3'd2,
    REG_PRINCIPAL  = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_TANGENT_P1 = 3'd6,
    REG_TANGENT_P2 = 3'd7
  } reg_index_t;

  // Reset values of the configuration registers.
  localparam logic [23:0] XI_RESET    = 24'd2097152;
  localparam logic [23:0] FOCAL_RESET = 24'd2048000;
  localparam logic [31:0] PP_RESET    = 32'd251663360;

  // Pixel range.
  localparam pixel_t PIX_MAX = 20'sh7FFFF;
  localparam pixel_t PIX_MIN = 20'sh80000;

  // Sideband that travels with a word up to the denominator.
  typedef struct packed {
    logic        zero;
    logic        x_neg;
    logic        y_neg;
    logic        x_nz;
    logic        y_nz;
    logic [31:0] ax;
    logic [31:0] ay;
    coord_t      z;
  } side_t;

  // Flags that travel with a word after the denominator.
  typedef struct packed {
    logic zero;
    logic dpos;
    logic x_neg;
    logic y_neg;
    logic x_nz;
    logic y_nz;
    logic sat;
  } flag_t;

endpackage

// File: rtl/core/ocp_if.sv
interface ocp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ocp_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] pixel_u;
  logic signed [19:0] pixel_v;
  logic               degenerate;
  logic               saturated;

  modport source (output valid, output pixel_u, output pixel_v, output degenerate,
                  output saturated, input ready);
  modport sink (input valid, input pixel_u, input pixel_v, input degenerate,
                input saturated, output ready);
endinterface

// File: rtl/core/ocp_isqrt.sv
module ocp_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  ocp_pkg::sumsq_t rad,
  output logic            vld_out,
  output ocp_pkg::root_t  root
);
  import ocp_pkg::*;

  // One result bit per stage, digit by digit from the top.
  sumsq_t                rad_r  [SQRT_STEPS-1];
  logic [33:0]           rem_r  [SQRT_STEPS-1];
  root_t                 root_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    sumsq_t      rad_in;
    logic [33:0] rem_in;
    root_t       root_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign rem_sh = {rem_in, rad_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_in[30:0], ge};
      end
    end

    // The last stage keeps only the root.
    if (i < SQRT_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i] <= {rad_in[61:0], 2'b00};
          rem_r[i] <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        end
      end
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], vld_in};
    end
  end

  assign vld_out = vld_r[SQRT_STEPS-1];
  assign root    = root_r[SQRT_STEPS-1];

endmodule

// File: rtl/core/ocp_div.sv
module ocp_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  logic [31:0]     num,
  input  ocp_pkg::denom_t den,
  output logic            vld_out,
  output ocp_pkg::quot_t  quo,
  output logic            ovf
);
  import ocp_pkg::*;

  // Stage zero decides overflow: the quotient of num * 2^41 / den reaches 2^22
  // exactly when num * 2^19 is not below den. Each later stage yields one bit.
  denom_t               rem_r [DIV_STEPS];
  denom_t               den_r [DIV_STEPS];
  quot_t                quo_r [DIV_STEPS+1];
  logic [DIV_STEPS:0]   ovf_r;
  logic [DIV_STEPS:0]   vld_r;
  denom_t               num_sh;
  logic                 ovf_nxt;

  assign num_sh  = {6'd0, num, 19'd0};
  assign ovf_nxt = (num_sh >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf_nxt ? '0 : num_sh;
      den_r[0] <= den;
      quo_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [57:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_r[i-1], 1'b0};
    assign ge     = (rem_sh >= {1'b0, den_r[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= {quo_r[i-1][DIV_STEPS-2:0], ge};
      end
    end

    if (i < DIV_STEPS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? 57'(rem_sh - {1'b0, den_r[i-1]}) : rem_sh[56:0];
          den_r[i] <= den_r[i-1];
        end
      end
    end
  end

  // Valid and overflow bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS-1:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r <= {ovf_r[DIV_STEPS-1:0], ovf_nxt};
    end
  end

  assign vld_out = vld_r[DIV_STEPS];
  assign quo     = quo_r[DIV_STEPS];
  assign ovf     = ovf_r[DIV_STEPS];

endmodule

// File: rtl/core/omni_camera_project_core.sv
// Unified omnidirectional camera projection with radial and tangential
// distortion. Each word on the input channel is one 3D point in signed Q16.16;
// each word on the output channel is its pixel in signed Q16.4 with a
// degenerate flag (zero point) and a saturated flag (non-positive denominator,
// clamped normalised coordinate or clamped pixel). The datapath is a fixed
// pipeline of 70 register stages: 3 for the sum of squares, 32 for the
// bit-per-stage square root, 1 for the denominator, 23 for the two
// bit-per-stage dividers, 10 for distortion and focal scaling, and the output
// register. The whole pipeline advances whenever the output register is empty
// or being taken, and then a new word is taken every cycle. Configuration
// registers are to be written only while no word is in flight.
module omni_camera_project_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  ocp_pkg::reg_index_t cfg_index,
  input  logic [31:0]         cfg_wdata,
  ocp_point_if.sink           in_pt,
  ocp_pixel_if.source         out_px
);
  import ocp_pkg::*;

  localparam int unsigned MATH_STAGES = 10;

  // Configuration registers.
  logic [23:0] xi_r;
  logic [23:0] fx_r;
  logic [23:0] fy_r;
  logic [31:0] pp_r;
  logic [31:0] k1_r;
  logic [31:0] k2_r;
  logic [31:0] p1_r;
  logic [31:0] p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xi_r <= XI_RESET;
      fx_r <= FOCAL_RESET;
      fy_r <= FOCAL_RESET;
      pp_r <= PP_RESET;
      k1_r <= '0;
      k2_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIRROR_XI:  xi_r <= cfg_wdata[23:0];
        REG_FOCAL_X:    fx_r <= cfg_wdata[23:0];
        REG_FOCAL_Y:    fy_r <= cfg_wdata[23:0];
        REG_PRINCIPAL:  pp_r <= cfg_wdata;
        REG_RADIAL_K1:  k1_r <= cfg_wdata;
        REG_RADIAL_K2:  k2_r <= cfg_wdata;
        REG_TANGENT_P1: p1_r <= cfg_wdata;
        REG_TANGENT_P2: p2_r <= cfg_wdata;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take a word.
  logic en;
  logic out_vld_r;

  assign en           = !out_vld_r || out_px.ready;
  assign in_pt.ready  = en;
  assign out_px.valid = out_vld_r;

  // Stage 1: magnitudes and sign flags.
  side_t s1_side_r;
  side_t s1_side_nxt;
  logic  [31:0] az_nxt;
  logic  [31:0] s1_az_r;
  logic  s1_vld_r;

  always_comb begin
    s1_side_nxt.x_neg = in_pt.point_x[31];
    s1_side_nxt.y_neg = in_pt.point_y[31];
    s1_side_nxt.x_nz  = (in_pt.point_x != '0);
    s1_side_nxt.y_nz  = (in_pt.point_y != '0);
    s1_side_nxt.zero  = (in_pt.point_x == '0) && (in_pt.point_y == '0) &&
                        (in_pt.point_z == '0);
    s1_side_nxt.ax    = in_pt.point_x[31] ? (~in_pt.point_x + 32'd1) : in_pt.point_x;
    s1_side_nxt.ay    = in_pt.point_y[31] ? (~in_pt.point_y + 32'd1) : in_pt.point_y;
    s1_side_nxt.z     = in_pt.point_z;
    az_nxt            = in_pt.point_z[31] ? (~in_pt.point_z + 32'd1) : in_pt.point_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_az_r   <= az_nxt;
    end
  end

  // Stage 2: squares.
  side_t       s2_side_r;
  logic [63:0] s2_sqx_r;
  logic [63:0] s2_sqy_r;
  logic [63:0] s2_sqz_r;
  logic        s2_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s1_side_r;
      s2_sqx_r  <= s1_side_r.ax * s1_side_r.ax;
      s2_sqy_r  <= s1_side_r.ay * s1_side_r.ay;
      s2_sqz_r  <= s1_az_r * s1_az_r;
    end
  end

  // Stage 3: squared norm, exact.
  side_t  s3_side_r;
  sumsq_t s3_sum_r;
  logic   s3_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s2_side_r;
      s3_sum_r  <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_pt.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Norm by square root; sideband delayed to match.
  logic  sq_vld;
  root_t sq_root;
  side_t sq_side_r [SQRT_STEPS];

  ocp_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (s3_vld_r),
    .rad     (s3_sum_r),
    .vld_out (sq_vld),
    .root    (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= s3_side_r;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // Stage 4: denominator D = z * 2^21 + xi * N in units of 2^-37.
  side_t              sq_side;
  logic [55:0]        xi_root;
  logic signed [57:0] den_nxt;
  logic signed [57:0] s4_den_r;
  side_t              s4_side_r;
  logic               s4_vld_r;
  flag_t              s4_flag;

  assign sq_side = sq_side_r[SQRT_STEPS-1];
  assign xi_root = xi_r * sq_root;
  assign den_nxt = $signed({{5{sq_side.z[31]}}, sq_side.z, 21'd0}) + $signed({2'b00, xi_root});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_den_r  <= den_nxt;
      s4_side_r <= sq_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld;
    end
  end

  always_comb begin
    s4_flag.zero  = s4_side_r.zero;
    s4_flag.dpos  = !s4_den_r[57] && (s4_den_r != '0);
    s4_flag.x_neg = s4_side_r.x_neg;
    s4_flag.y_neg = s4_side_r.y_neg;
    s4_flag.x_nz  = s4_side_r.x_nz;
    s4_flag.y_nz  = s4_side_r.y_nz;
    s4_flag.sat   = 1'b0;
  end

  // Normalised coordinates by division; flags delayed to match.
  logic  du_vld;
  logic  dv_vld;
  quot_t du_quo;
  quot_t dv_quo;
  logic  du_ovf;
  logic  dv_ovf;
  flag_t dv_flag_r [DIV_STEPS+1];

  ocp_div u_div_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (s4_vld_r),
    .num     (s4_side_r.ax),
    .den     (s4_den_r[56:0]),
    .vld_out (du_vld),
    .quo     (du_quo),
    .ovf     (du_ovf)
  );

  ocp_div u_div_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (s4_vld_r),
    .num     (s4_side_r.ay),
    .den     (s4_den_r[56:0]),
    .vld_out (dv_vld),
    .quo     (dv_quo),
    .ovf     (dv_ovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_flag_r[0] <= s4_flag;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        dv_flag_r[i] <= dv_flag_r[i-1];
      end
    end
  end

  // Distortion and focal stages: flags and valid bits in one line.
  flag_t                  m_flag_r [MATH_STAGES];
  logic [MATH_STAGES-1:0] m_vld_r;
  flag_t                  m0_flag_nxt;

  always_comb begin
    m0_flag_nxt     = dv_flag_r[DIV_STEPS];
    m0_flag_nxt.sat = du_ovf || dv_ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_flag_r[0] <= m0_flag_nxt;
      for (int i = 1; i < MATH_STAGES; i++) begin
        m_flag_r[i] <= m_flag_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= '0;
    end else if (en) begin
      m_vld_r <= {m_vld_r[MATH_STAGES-2:0], du_vld && dv_vld};
    end
  end

  // M0: signed normalised coordinates in Q.20; a magnitude of four or more
  // is held just below four.
  quot_t              u_mag;
  quot_t              v_mag;
  logic signed [22:0] m0_u_r;
  logic signed [22:0] m0_v_r;

  assign u_mag = du_ovf ? '1 : du_quo;
  assign v_mag = dv_ovf ? '1 : dv_quo;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_u_r <= dv_flag_r[DIV_STEPS].x_neg ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
      m0_v_r <= dv_flag_r[DIV_STEPS].y_neg ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
    end
  end

  // M1: products of the coordinates.
  logic signed [45:0] m1_uu_r;
  logic signed [45:0] m1_vv_r;
  logic signed [45:0] m1_uv_r;
  logic signed [22:0] m1_u_r;
  logic signed [22:0] m1_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_uu_r <= m0_u_r * m0_u_r;
      m1_vv_r <= m0_v_r * m0_v_r;
      m1_uv_r <= m0_u_r * m0_v_r;
      m1_u_r  <= m0_u_r;
      m1_v_r  <= m0_v_r;
    end
  end

  // M2: r2, the cross term and the tangential sums in Q.20.
  logic [44:0]        r2_sum;
  logic [24:0]        r2_nxt;
  logic [24:0]        m2_r2_r;
  logic [25:0]        m2_tu_r;
  logic [25:0]        m2_tv_r;
  logic signed [25:0] m2_uv_r;
  logic signed [22:0] m2_u_r;
  logic signed [22:0] m2_v_r;

  assign r2_sum = m1_uu_r[44:0] + m1_vv_r[44:0];
  assign r2_nxt = r2_sum[44:20];

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r2_r <= r2_nxt;
      m2_tu_r <= {1'b0, r2_nxt} + {1'b0, m1_uu_r[43:20], 1'b0};
      m2_tv_r <= {1'b0, r2_nxt} + {1'b0, m1_vv_r[43:20], 1'b0};
      m2_uv_r <= m1_uv_r[45:20];
      m2_u_r  <= m1_u_r;
      m2_v_r  <= m1_v_r;
    end
  end

  // M3: r4 and the first coefficient products.
  logic [49:0]        r2_sq;
  logic [29:0]        m3_r4_r;
  logic signed [57:0] m3_k1r2_r;
  logic signed [57:0] m3_a1_r;
  logic signed [58:0] m3_a2_r;
  logic signed [58:0] m3_b1_r;
  logic signed [57:0] m3_b2_r;
  logic signed [22:0] m3_u_r;
  logic signed [22:0] m3_v_r;

  assign r2_sq = m2_r2_r * m2_r2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r4_r   <= r2_sq[49:20];
      m3_k1r2_r <= $signed(k1_r) * $signed({1'b0, m2_r2_r});
      m3_a1_r   <= $signed(p1_r) * m2_uv_r;
      m3_a2_r   <= $signed(p2_r) * $signed({1'b0, m2_tu_r});
      m3_b1_r   <= $signed(p1_r) * $signed({1'b0, m2_tv_r});
      m3_b2_r   <= $signed(p2_r) * m2_uv_r;
      m3_u_r    <= m2_u_r;
      m3_v_r    <= m2_v_r;
    end
  end

  // M4: k2 term in units of 2^-48 and tangential offsets in units of 2^-50.
  logic signed [62:0] m4_k2r4_r;
  logic signed [57:0] m4_k1r2_r;
  logic signed [59:0] m4_du_r;
  logic signed [59:0] m4_dv_r;
  logic signed [22:0] m4_u_r;
  logic signed [22:0] m4_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m4_k2r4_r <= $signed(k2_r) * $signed({1'b0, m3_r4_r});
      m4_k1r2_r <= m3_k1r2_r;
      m4_du_r   <= $signed({m3_a1_r[57], m3_a1_r, 1'b0}) + $signed({m3_a2_r[58], m3_a2_r});
      m4_dv_r   <= $signed({m3_b1_r[58], m3_b1_r}) + $signed({m3_b2_r[57], m3_b2_r, 1'b0});
      m4_u_r    <= m3_u_r;
      m4_v_r    <= m3_v_r;
    end
  end

  // M5: radial factor in Q.20, offsets floored to units of 2^-40.
  logic signed [63:0] dr_sum;
  logic signed [35:0] m5_dr_r;
  logic signed [49:0] m5_du_r;
  logic signed [49:0] m5_dv_r;
  logic signed [22:0] m5_u_r;
  logic signed [22:0] m5_v_r;

  assign dr_sum = 64'sh0001_0000_0000_0000 + 64'(m4_k1r2_r) + 64'(m4_k2r4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m5_dr_r <= dr_sum[63:28];
      m5_du_r <= m4_du_r[59:10];
      m5_dv_r <= m4_dv_r[59:10];
      m5_u_r  <= m4_u_r;
      m5_v_r  <= m4_v_r;
    end
  end

  // M6: radial scaling.
  logic signed [58:0] m6_mu_r;
  logic signed [58:0] m6_mv_r;
  logic signed [49:0] m6_du_r;
  logic signed [49:0] m6_dv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m6_mu_r <= m5_u_r * m5_dr_r;
      m6_mv_r <= m5_v_r * m5_dr_r;
      m6_du_r <= m5_du_r;
      m6_dv_r <= m5_dv_r;
    end
  end

  // M7: distorted coordinates in Q.20.
  logic signed [60:0] ud_sum;
  logic signed [60:0] vd_sum;
  logic signed [40:0] m7_ud_r;
  logic signed [40:0] m7_vd_r;

  assign ud_sum = 61'(m6_mu_r) + 61'(m6_du_r);
  assign vd_sum = 61'(m6_mv_r) + 61'(m6_dv_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m7_ud_r <= ud_sum[60:20];
      m7_vd_r <= vd_sum[60:20];
    end
  end

  // M8: focal scaling, split into a high and a low partial product.
  logic signed [45:0] m8_uh_r;
  logic [43:0]        m8_ul_r;
  logic signed [45:0] m8_vh_r;
  logic [43:0]        m8_vl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m8_uh_r <= $signed({1'b0, fx_r}) * $signed(m7_ud_r[40:20]);
      m8_ul_r <= fx_r * m7_ud_r[19:0];
      m8_vh_r <= $signed({1'b0, fy_r}) * $signed(m7_vd_r[40:20]);
      m8_vl_r <= fy_r * m7_vd_r[19:0];
    end
  end

  // M9: round half up to Q.4 and add the principal point.
  logic signed [65:0] pu_full;
  logic signed [65:0] pv_full;
  logic signed [38:0] m9_pu_r;
  logic signed [38:0] m9_pv_r;

  assign pu_full = (66'(m8_uh_r) <<< 20) + $signed({22'd0, m8_ul_r}) + 66'sd134217728;
  assign pv_full = (66'(m8_vh_r) <<< 20) + $signed({22'd0, m8_vl_r}) + 66'sd134217728;

  always_ff @(posedge clk) begin
    if (en) begin
      m9_pu_r <= 39'($signed(pu_full[65:28])) + $signed({23'd0, pp_r[15:0]});
      m9_pv_r <= 39'($signed(pv_full[65:28])) + $signed({23'd0, pp_r[31:16]});
    end
  end

  // Output: clamp, then the zero point and non-positive denominator cases.
  flag_t  fin_flag;
  pixel_t pu_nxt;
  pixel_t pv_nxt;
  logic   deg_nxt;
  logic   sat_nxt;

  assign fin_flag = m_flag_r[MATH_STAGES-1];

  always_comb begin
    sat_nxt = fin_flag.sat;
    deg_nxt = 1'b0;
    if (m9_pu_r > 39'sd524287) begin
      pu_nxt  = PIX_MAX;
      sat_nxt = 1'b1;
    end else if (m9_pu_r < -39'sd524288) begin
      pu_nxt  = PIX_MIN;
      sat_nxt = 1'b1;
    end else begin
      pu_nxt = m9_pu_r[19:0];
    end
    if (m9_pv_r > 39'sd524287) begin
      pv_nxt  = PIX_MAX;
      sat_nxt = 1'b1;
    end else if (m9_pv_r < -39'sd524288) begin
      pv_nxt  = PIX_MIN;
      sat_nxt = 1'b1;
    end else begin
      pv_nxt = m9_pv_r[19:0];
    end
    if (fin_flag.zero) begin
      pu_nxt  = '0;
      pv_nxt  = '0;
      deg_nxt = 1'b1;
      sat_nxt = 1'b0;
    end else if (!fin_flag.dpos) begin
      pu_nxt  = !fin_flag.x_nz ? '0 : (fin_flag.x_neg ? PIX_MIN : PIX_MAX);
      pv_nxt  = !fin_flag.y_nz ? '0 : (fin_flag.y_neg ? PIX_MIN : PIX_MAX);
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m_vld_r[MATH_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px.pixel_u    <= pu_nxt;
      out_px.pixel_v    <= pv_nxt;
      out_px.degenerate <= deg_nxt;
      out_px.saturated  <= sat_nxt;
    end
  end

`ifndef SYNTHESIS
  // A degenerate word is never also saturated.
  a_deg_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> !(out_px.degenerate && out_px.saturated))
    else $error("degenerate and saturated both set");

  // A degenerate word carries pixel (0,0).
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && out_px.degenerate) |-> (out_px.pixel_u == '0 && out_px.pixel_v == '0))
    else $error("degenerate word with non-zero pixel");

  // A stalled output register holds the input side back.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && !out_px.ready) |-> !in_pt.ready)
    else $error("input accepted while the pipeline is stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_px.valid)
    else $error("output valid after reset");
`endif

endmodule

// File: dv/tb_omni_camera_project_core.sv
module tb_omni_camera_project_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ocp_pkg::*;

  localparam longint UV_CLAMP  = 64'd4194304;
  localparam int     DRAIN_CYC = 100;

  // Expected pixel word.
  typedef struct {
    pixel_t u;
    pixel_t v;
    logic   degenerate;
    logic   saturated;
  } pixel_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  reg_index_t  cfg_index;
  logic [31:0] cfg_wdata;

  ocp_point_if pt_if ();
  ocp_pixel_if px_if ();

  omni_camera_project_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pt     (pt_if.sink),
    .out_px    (px_if.source)
  );

  // Local copy of the camera registers.
  logic [23:0] cam_xi;
  logic [23:0] cam_fx;
  logic [23:0] cam_fy;
  logic [31:0] cam_pp;
  logic [31:0] cam_k1;
  logic [31:0] cam_k2;
  logic [31:0] cam_p1;
  logic [31:0] cam_p2;

  pixel_word_t pending_pixels[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  // Clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Integer square root of a 64-bit sum of squares.
  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalised coordinate in Q.20 with clamping below four.
  function automatic longint norm_coord(longint c, longint d, inout bit clamped);
    logic [127:0] num;
    logic [127:0] quo;
    longint       q;
    num = 128'(c < 0 ? -c : c) << 41;
    quo = num / 128'(d);
    if (quo >= 128'(UV_CLAMP)) begin
      clamped = 1'b1;
      q = UV_CLAMP - 1;
    end else begin
      q = longint'(quo[63:0]);
    end
    return c < 0 ? -q : q;
  endfunction

  // Focal scaling, rounding to Q.4 and principal point offset, saturating.
  function automatic pixel_t scale_pixel(longint f, longint m, longint c, inout bit clipped);
    longint p;
    p = ((f * m + (64'sd1 <<< 27)) >>> 28) + c;
    if (p > 524287) begin
      clipped = 1'b1;
      return PIX_MAX;
    end
    if (p < -524288) begin
      clipped = 1'b1;
      return PIX_MIN;
    end
    return pixel_t'(p);
  endfunction

  // Projects one point with the current camera registers.
  function automatic pixel_word_t project_point(coord_t px, coord_t py, coord_t pz);
    pixel_word_t     w;
    longint          x, y, z, d, u, v, uu, vv, uv, r2, r4, dr, du, dv, ud, vd;
    longint          k1, k2, p1, p2;
    longint unsigned ax, ay, az, s;
    bit              sat;
    x = longint'(px);
    y = longint'(py);
    z = longint'(pz);
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    s = ax * ax + ay * ay + az * az;
    sat = 1'b0;
    w.degenerate = 1'b0;
    if (s == 0) begin
      w.u = '0;
      w.v = '0;
      w.degenerate = 1'b1;
      w.saturated = 1'b0;
      return w;
    end
    d = z * 2097152 + longint'({40'd0, cam_xi}) * longint'(int_sqrt(s));
    if (d <= 0) begin
      w.u = x > 0 ? PIX_MAX : (x < 0 ? PIX_MIN : pixel_t'(0));
      w.v = y > 0 ? PIX_MAX : (y < 0 ? PIX_MIN : pixel_t'(0));
      w.saturated = 1'b1;
      return w;
    end
    u = norm_coord(x, d, sat);
    v = norm_coord(y, d, sat);
    k1 = longint'($signed(cam_k1));
    k2 = longint'($signed(cam_k2));
    p1 = longint'($signed(cam_p1));
    p2 = longint'($signed(cam_p2));
    uu = (u * u) >>> 20;
    vv = (v * v) >>> 20;
    uv = (u * v) >>> 20;
    r2 = (u * u + v * v) >>> 20;
    r4 = (r2 * r2) >>> 20;
    dr = ((64'sd1 <<< 48) + k1 * r2 + k2 * r4) >>> 28;
    du = 2 * p1 * uv + p2 * (r2 + 2 * uu);
    dv = p1 * (r2 + 2 * vv) + 2 * p2 * uv;
    ud = (u * dr + (du >>> 10)) >>> 20;
    vd = (v * dr + (dv >>> 10)) >>> 20;
    w.u = scale_pixel(longint'({40'd0, cam_fx}), ud, longint'({48'd0, cam_pp[15:0]}), sat);
    w.v = scale_pixel(longint'({40'd0, cam_fy}), vd, longint'({48'd0, cam_pp[31:16]}), sat);
    w.saturated = sat;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Predicts on each accepted point and checks each accepted pixel word.
  always @(posedge clk) begin
    pixel_word_t want;
    if (rst_n && pt_if.valid && pt_if.ready)
      pending_pixels.push_back(project_point(pt_if.point_x, pt_if.point_y, pt_if.point_z));
    if (rst_n && px_if.valid && px_if.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (px_if.pixel_u !== want.u) report_mismatch("pixel_u", px_if.pixel_u, want.u);
        if (px_if.pixel_v !== want.v) report_mismatch("pixel_v", px_if.pixel_v, want.v);
        if (px_if.degenerate !== want.degenerate)
          report_mismatch("degenerate", px_if.degenerate, want.degenerate);
        if (px_if.saturated !== want.saturated)
          report_mismatch("saturated", px_if.saturated, want.saturated);
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    px_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one point, idling at random first; valid stays high afterwards.
  task automatic send_point(coord_t x, coord_t y, coord_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid = 1'b0;
      @(negedge clk);
    end
    pt_if.valid   = 1'b1;
    pt_if.point_x = x;
    pt_if.point_y = y;
    pt_if.point_z = z;
    do @(posedge clk); while (!pt_if.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every pixel word has come back.
  task automatic wait_drained();
    pt_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MIRROR_XI:  cam_xi = value[23:0];
      REG_FOCAL_X:    cam_fx = value[23:0];
      REG_FOCAL_Y:    cam_fy = value[23:0];
      REG_PRINCIPAL:  cam_pp = value;
      REG_RADIAL_K1:  cam_k1 = value;
      REG_RADIAL_K2:  cam_k2 = value;
      REG_TANGENT_P1: cam_p1 = value;
      default:        cam_p2 = value;
    endcase
  endtask

  task automatic write_camera(logic [23:0] xi, logic [23:0] fx, logic [23:0] fy,
                              logic [31:0] pp, logic [31:0] k1, logic [31:0] k2,
                              logic [31:0] p1, logic [31:0] p2);
    wait_drained();
    write_reg(REG_MIRROR_XI, {8'd0, xi});
    write_reg(REG_FOCAL_X, {8'd0, fx});
    write_reg(REG_FOCAL_Y, {8'd0, fy});
    write_reg(REG_PRINCIPAL, pp);
    write_reg(REG_RADIAL_K1, k1);
    write_reg(REG_RADIAL_K2, k2);
    write_reg(REG_TANGENT_P1, p1);
    write_reg(REG_TANGENT_P2, p2);
  endtask

  // A random point: half in front of the camera, some anywhere, some tiny.
  task automatic send_random_point();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5)
      send_point($signed($urandom_range(8000000)) - 4000000,
                 $signed($urandom_range(8000000)) - 4000000,
                 $signed($urandom_range(6000000)) + 1000);
    else if (sel < 8)
      send_point($urandom, $urandom, $urandom);
    else
      send_point($signed($urandom_range(6)) - 3, $signed($urandom_range(6)) - 3,
                 $signed($urandom_range(6)) - 3);
  endtask

  // Points at the edges of the fields, the zero point and a zero denominator, reset camera.
  task automatic test_special_points();
    send_point(0, 0, 0);                               // zero point
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh80000000, 0, 0);
    send_point(0, 32'sh7FFFFFFF, 32'sh80000000);
    send_point(65536, -65536, 65536);
    send_point(0, 0, 65536);                           // optical axis
    send_point(0, 0, -65536);                          // behind, D is zero
    send_point(1, -1, 0);
    send_point(-12345678, 23456789, 1000);
  endtask

  // Denominator below zero, clamped coordinates and clipped pixels.
  task automatic test_saturation();
    write_camera(24'd0, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(65536, -65536, -65536);                 // negative denominator
    send_point(0, 65536, -1);
    send_point(65536000, 65536, 1);                    // clamped u
    send_point(-65536, -65536000, 1);                  // clamped v
    send_point(65536, 65536, 655360);                  // in front of the camera, pixel in range
    write_camera(24'hFFFFFF, 24'd0, 24'd0, 32'd0, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000);
    send_point(65536, 65536, -65536);
    send_point(-65536, 65536, 65536);
    send_point(32'sh7FFFFFFF, 32'sh80000000, 1);
    write_camera(24'd0, 24'd4096000, 24'd4096000, 32'h0FF00FF0, 32'hF0000000,
                 32'h10000000, 32'hC0000000, 32'h40000000);
    send_point(300000, -200000, 65536);
    send_point(-300000, 200000, 65536);
  endtask

  // Random points over several camera settings and idling phases.
  task automatic test_random_points();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 0)
        write_camera(XI_RESET, FOCAL_RESET, FOCAL_RESET, PP_RESET, 0, 0, 0, 0);
      else if (phase % 3 == 0)
        write_camera(24'($urandom), 24'($urandom), 24'($urandom), $urandom, $urandom,
                     $urandom, $urandom, $urandom);
      else
        write_camera(24'($urandom_range(4194304)), 24'($urandom_range(8192000)),
                     24'($urandom_range(8192000)), $urandom,
                     $signed($urandom_range(67108864)) - 33554432,
                     $signed($urandom_range(16777216)) - 8388608,
                     $signed($urandom_range(4194304)) - 2097152,
                     $signed($urandom_range(4194304)) - 2097152);
      repeat (48) send_random_point();
      if (phase == 5) begin
        wait_drained();
        repeat (10) send_random_point();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MIRROR_XI;
    cfg_wdata     = '0;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    px_if.ready   = 1'b1;
    cam_xi = XI_RESET;
    cam_fx = FOCAL_RESET;
    cam_fy = FOCAL_RESET;
    cam_pp = PP_RESET;
    cam_k1 = '0;
    cam_k2 = '0;
    cam_p1 = '0;
    cam_p2 = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_special_points();
    test_saturation();
    test_random_points();
    wait_drained();

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_omni_camera_project_core OK");
    end else begin
      $display("tb_omni_camera_project_core NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb_omni_camera_project_core NOT OK");
    $finish;
  end

endmodule
